// ----- hdl/b64e_pkg.sv -----
// Shared types and constants for the Base64 stream encoder.
// Holds the group entry passed from front end to back end and the alphabet mapping.
// No dependencies.
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // One group of up to three bytes, ready for character output.
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  npad;
        logic        fin;
    } t_group;

    typedef logic [1:0] t_idx;

    // Standard Base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        c = 7'h2F;
        if (v < 6'd26) begin
            c = 7'h41 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'h61 + {1'b0, v} - 7'd26;
        end else if (v < 6'd62) begin
            c = 7'h30 + {1'b0, v} - 7'd52;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end
        return c;
    endfunction

endpackage

// ----- hdl/base64_stream_encoder_top.sv -----
// Base64 stream encoder (standard alphabet, padded), one byte in per transfer.
// The first character of a group passes through the group queue and then the output register
// after the transfer of the byte that closes it.
// Throughput: one character per cycle from the back end while groups are queued and pop is high;
// the front end takes a byte every cycle while the group queue has room.
// Reset (synchronous, active low) clears pending bytes, the queue and the output valid flag.
module base64_stream_encoder_top import b64e_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] o_out_char,
    output logic       o_end_of_text
);

    t_group q_in;
    t_group q_out;
    logic   q_push;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    logic   out_valid;

    assign full = q_full;

    b64e_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (push && !q_full),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_grp_push   (q_push),
        .o_grp        (q_in)
    );

    b64e_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grp         (q_out),
        .i_grp_empty   (q_empty),
        .o_grp_pop     (q_pop),
        .o_valid       (out_valid),
        .i_take        (pop),
        .o_out_char    (o_out_char),
        .o_end_of_text (o_end_of_text)
    );

    assign empty = !out_valid;

endmodule

// ----- hdl/b64e_front.sv -----
// Front end of the Base64 encoder: collects bytes and forms complete or padded groups.
// Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_grp_push,
    output t_group     o_grp
);

    logic [15:0] r_pend;
    logic [15:0] n_pend;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;

    always_comb begin
        n_pend     = r_pend;
        n_cnt      = r_cnt;
        o_grp_push = 1'b0;
        o_grp      = '{group: {r_pend, i_data_byte}, npad: 2'd0, fin: i_final_byte};
        if (i_valid) begin
            // A count of three never occurs; it behaves like two.
            if (r_cnt[1]) begin
                o_grp_push = 1'b1;
                n_pend     = '0;
                n_cnt      = '0;
            end else if (i_final_byte && r_cnt == 2'd1) begin
                o_grp_push  = 1'b1;
                o_grp.group = {r_pend[15:8], i_data_byte, 8'h00};
                o_grp.npad  = 2'd1;
                n_pend      = '0;
                n_cnt       = '0;
            end else if (i_final_byte) begin
                o_grp_push  = 1'b1;
                o_grp.group = {i_data_byte, 16'h0000};
                o_grp.npad  = 2'd2;
                n_pend      = '0;
                n_cnt       = '0;
            end else begin
                if (r_cnt == 2'd0) begin
                    n_pend = {i_data_byte, 8'h00};
                end else begin
                    n_pend = {r_pend[15:8], i_data_byte};
                end
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ----- hdl/b64e_fifo.sv -----
// Small group queue between the encoder front end and back end.
// Depends on b64e_pkg.
module b64e_fifo import b64e_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_group o_data,
    output logic   o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- hdl/b64e_back.sv -----
// Back end of the Base64 encoder: turns the queued group into four characters, one per cycle
// while the output register is empty or being taken, into that register. Depends on b64e_pkg.
module b64e_back import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_group     i_grp,
    input  logic       i_grp_empty,
    output logic       o_grp_pop,
    output logic       o_valid,
    input  logic       i_take,
    output logic [6:0] o_out_char,
    output logic       o_end_of_text
);

    t_idx       r_idx;
    logic       r_valid;
    logic [6:0] r_char;
    logic       r_eot;
    logic       adv;
    logic [5:0] sextet;
    logic       is_pad;
    logic [6:0] n_char;

    // The output register is refilled when it is empty or being taken and a group is queued.
    assign adv       = (!r_valid || i_take) && !i_grp_empty;
    assign o_grp_pop = adv && (r_idx == 2'd3);

    always_comb begin
        case (r_idx)
            2'd0:    sextet = i_grp.group[23:18];
            2'd1:    sextet = i_grp.group[17:12];
            2'd2:    sextet = i_grp.group[11:6];
            default: sextet = i_grp.group[5:0];
        endcase
        // Pads occupy the last npad character slots.
        is_pad = ({1'b0, r_idx} >= (3'd4 - {1'b0, i_grp.npad}));
        n_char = is_pad ? PAD_CHAR : sextet_char(sextet);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_char <= n_char;
            r_eot  <= i_grp.fin && (r_idx == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_idx   <= r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_end_of_text = r_eot;

endmodule

// ----- test/tb_base64_stream_encoder_top.sv -----
// Self-checking testbench for base64_stream_encoder_top: a directed table, then random messages.
// Expected characters come from the table text or a predictor here; uses PAD_CHAR from b64e_pkg.
// Depends on hdl/b64e_pkg.sv and hdl/base64_stream_encoder_top.sv.
module tb_base64_stream_encoder_top import b64e_pkg::*;;

    localparam logic [8*64-1:0] B64_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int N_DIRECTED = 23;
    localparam int N_RANDOM   = 107;

    // One directed row. When typed is set, text holds the expected characters,
    // first character in the top byte, and nres says how many of them arrive.
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic        typed;
        logic [2:0]  nres;
        logic [31:0] text;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_final_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [6:0] o_out_char;
    logic       o_end_of_text;

    // Predictor state: bytes waiting for the rest of their group.
    logic [15:0] held_bytes = 16'h0000;
    logic [1:0]  held_cnt = 2'd0;

    logic [6:0] want_char_q[$];
    logic       want_eot_q[$];
    int         errors = 0;
    logic       steady = 1'b0;
    t_row       stim_table [0:N_DIRECTED-1];

    base64_stream_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .empty         (empty),
        .pop           (pop),
        .o_out_char    (o_out_char),
        .o_end_of_text (o_end_of_text)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [6:0] symbol_of(input logic [5:0] v);
        return B64_SYMBOLS[8*(63-v) +: 7];
    endfunction

    // Advances the encoder model by one byte; chars[3] is the first character out.
    task automatic encode_byte(input logic [7:0] b, input logic f, output int n,
                               output logic [3:0][6:0] chars);
        logic [23:0] grp;
        n = 4;
        chars = '0;
        if (held_cnt >= 2'd2) begin
            grp = {held_bytes, b};
            chars = {symbol_of(grp[23:18]), symbol_of(grp[17:12]),
                     symbol_of(grp[11:6]), symbol_of(grp[5:0])};
        end else if (f && held_cnt == 2'd1) begin
            grp = {held_bytes[15:8], b, 8'h00};
            chars = {symbol_of(grp[23:18]), symbol_of(grp[17:12]),
                     symbol_of(grp[11:6]), PAD_CHAR};
        end else if (f) begin
            grp = {b, 16'h0000};
            chars = {symbol_of(grp[23:18]), symbol_of(grp[17:12]), PAD_CHAR, PAD_CHAR};
        end else begin
            n = 0;
            if (held_cnt == 2'd0) begin
                held_bytes = {b, 8'h00};
            end else begin
                held_bytes[7:0] = b;
            end
            held_cnt = held_cnt + 2'd1;
        end
        if (n != 0) begin
            held_bytes = 16'h0000;
            held_cnt = 2'd0;
        end
    endtask

    // Offers one byte, waits for its transfer, then queues what it should produce.
    // Push is left high on return, so back-to-back bytes keep it asserted between them.
    task automatic send_item(input logic [7:0] b, input logic f, input logic typed,
                             input logic [2:0] nres, input logic [31:0] text);
        int n;
        logic [3:0][6:0] chars;
        while (!steady && $urandom_range(0, 99) < 25) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        i_final_byte <= f;
        do @(posedge i_clk); while (full);
        encode_byte(b, f, n, chars);
        if (typed) begin
            n = nres;
            for (int k = 0; k < 4; k++) begin
                chars[k] = text[8*k +: 7];
            end
        end
        for (int k = 3; k > 3 - n; k--) begin
            want_char_q.insert(want_char_q.size(), chars[k]);
            want_eot_q.insert(want_eot_q.size(), f && k == 4 - n);
        end
    endtask

    // Stops offering bytes until every queued character has been taken.
    task automatic hold_until_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (want_char_q.size() != 0);
    endtask

    // Receiver: checks each character transfer and throttles pop at random outside the steady phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (want_char_q.size() == 0) begin
                    $display("%0t: unexpected character: expected none actual %h/%b",
                             $time, o_out_char, o_end_of_text);
                    errors++;
                end else begin
                    if (o_out_char !== want_char_q[0]) begin
                        $display("%0t: out_char mismatch: expected %h actual %h",
                                 $time, want_char_q[0], o_out_char);
                        errors++;
                    end
                    if (o_end_of_text !== want_eot_q[0]) begin
                        $display("%0t: end_of_text mismatch: expected %b actual %b",
                                 $time, want_eot_q[0], o_end_of_text);
                        errors++;
                    end
                    void'(want_char_q.pop_front());
                    void'(want_eot_q.pop_front());
                end
            end
            pop <= steady || ($urandom_range(0, 99) >= 25);
        end
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int sent;
        int len;
        logic mid_drain_done;

        // Single final bytes at both extremes, pairs, full groups with and without the flag,
        // then text and alphabet edges left to the predictor.
        stim_table[0]  = {8'h00, 1'b1, 1'b1, 3'd4, "AA=="};
        stim_table[1]  = {8'hFF, 1'b1, 1'b1, 3'd4, "/w=="};
        stim_table[2]  = {8'h00, 1'b0, 1'b1, 3'd0, "    "};
        stim_table[3]  = {8'h00, 1'b1, 1'b1, 3'd4, "AAA="};
        stim_table[4]  = {8'hFF, 1'b0, 1'b1, 3'd0, "    "};
        stim_table[5]  = {8'hFF, 1'b1, 1'b1, 3'd4, "//8="};
        stim_table[6]  = {8'h00, 1'b0, 1'b1, 3'd0, "    "};
        stim_table[7]  = {8'h00, 1'b0, 1'b1, 3'd0, "    "};
        stim_table[8]  = {8'h00, 1'b0, 1'b1, 3'd4, "AAAA"};
        stim_table[9]  = {8'hFF, 1'b0, 1'b1, 3'd0, "    "};
        stim_table[10] = {8'hFF, 1'b0, 1'b1, 3'd0, "    "};
        stim_table[11] = {8'hFF, 1'b1, 1'b1, 3'd4, "////"};
        stim_table[12] = {8'h4D, 1'b0, 1'b0, 3'd0, "    "};
        stim_table[13] = {8'h61, 1'b0, 1'b0, 3'd0, "    "};
        stim_table[14] = {8'h6E, 1'b0, 1'b0, 3'd0, "    "};
        stim_table[15] = {8'h4D, 1'b1, 1'b0, 3'd0, "    "};
        stim_table[16] = {8'hFB, 1'b0, 1'b0, 3'd0, "    "};
        stim_table[17] = {8'hEF, 1'b0, 1'b0, 3'd0, "    "};
        stim_table[18] = {8'hBE, 1'b1, 1'b0, 3'd0, "    "};
        stim_table[19] = {8'h3F, 1'b0, 1'b0, 3'd0, "    "};
        stim_table[20] = {8'hFF, 1'b1, 1'b0, 3'd0, "    "};
        stim_table[21] = {8'h80, 1'b1, 1'b0, 3'd0, "    "};
        stim_table[22] = {8'h01, 1'b1, 1'b0, 3'd0, "    "};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(stim_table[r].data, stim_table[r].fin, stim_table[r].typed,
                      stim_table[r].nres, stim_table[r].text);
        end
        hold_until_drained();

        // Random messages, mostly short so that every partial-group case recurs often.
        sent = 0;
        mid_drain_done = 1'b0;
        while (sent < N_RANDOM) begin
            len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(4, 12))
                                              : int'($urandom_range(1, 3));
            for (int k = 0; k < len; k++) begin
                steady = (sent >= 40 && sent < 75);
                send_item(8'($urandom_range(0, 255)), k == len - 1, 1'b0, 3'd0, 32'h0);
                sent++;
            end
            if (!mid_drain_done && sent >= 95) begin
                hold_until_drained();
                mid_drain_done = 1'b1;
            end
        end
        steady = 1'b0;

        hold_until_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
